// ===== sv/smx_pkg.sv =====
package smx_pkg;

  // Default sizes of the stack and of the program space.
  localparam int STACK_DEPTH_DEF   = 512;
  localparam int PROGRAM_DEPTH_DEF = 1024;

  // Fixed field widths.
  localparam int WORD_W   = 32;
  localparam int OPCODE_W = 5;
  localparam int PC_OUT_W = 11;
  localparam int STATUS_W = 3;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_NOP = 5'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD = 5'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB = 5'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL = 5'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV = 5'd4;
  localparam logic [OPCODE_W-1:0] OP_EQU = 5'd5;
  localparam logic [OPCODE_W-1:0] OP_LTH = 5'd6;
  localparam logic [OPCODE_W-1:0] OP_LIT = 5'd7;
  localparam logic [OPCODE_W-1:0] OP_LOD = 5'd8;
  localparam logic [OPCODE_W-1:0] OP_STO = 5'd9;
  localparam logic [OPCODE_W-1:0] OP_INT = 5'd10;
  localparam logic [OPCODE_W-1:0] OP_JMP = 5'd11;
  localparam logic [OPCODE_W-1:0] OP_JPC = 5'd12;
  localparam logic [OPCODE_W-1:0] OP_RED = 5'd13;
  localparam logic [OPCODE_W-1:0] OP_WRT = 5'd14;
  localparam logic [OPCODE_W-1:0] OP_SWP = 5'd15;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_END   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADOP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

  // One input item: an instruction and the value for a read.
  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [WORD_W-1:0] operand;
    logic signed [WORD_W-1:0] read_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [PC_OUT_W-1:0]      next_pc;
    logic                     out_valid;
    logic signed [WORD_W-1:0] out_value;
    logic [STATUS_W-1:0]      status;
  } res_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic chk;
    logic rd2;
    logic exec;
    logic div_step;
    logic fin_go;
    logic swp2;
  } smx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early_done;
    logic div_go;
    logic div_last;
    logic out_free;
    logic swp_go;
  } smx_sts_t;

endpackage

// ===== sv/smx_ctrl.sv =====
module smx_ctrl
  import smx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  smx_sts_t sts,
  output smx_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_SWP2 = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_CHK;
      S_CHK:  state_next = sts.early_done ? S_FIN : S_RD2;
      S_RD2:  state_next = S_EXEC;
      S_EXEC: state_next = sts.div_go ? S_DIV : S_FIN;
      S_DIV:  if (sts.div_last) state_next = S_FIN;
      S_FIN:  if (sts.out_free) state_next = sts.swp_go ? S_SWP2 : S_IDLE;
      S_SWP2: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Commands decoded from the state.
  always_comb begin
    cmd.accept   = (state == S_IDLE) && start;
    cmd.chk      = (state == S_CHK);
    cmd.rd2      = (state == S_RD2);
    cmd.exec     = (state == S_EXEC);
    cmd.div_step = (state == S_DIV);
    cmd.fin_go   = (state == S_FIN) && sts.out_free;
    cmd.swp2     = (state == S_SWP2);
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/smx_dp.sv =====
module smx_dp
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  smx_cmd_t            cmd,
  output smx_sts_t            sts,
  input  in_item_t            in_item,
  input  logic                cfg_we,
  input  logic [PC_OUT_W-1:0] cfg_data,
  output logic                res_valid,
  input  logic                res_stall,
  output res_item_t           res_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PW = $clog2(PROGRAM_DEPTH + 1);

  // Architectural state.
  logic [WORD_W-1:0]   mem [STACK_DEPTH];
  logic [WORD_W-1:0]   rdata;
  logic [CW-1:0]       cnt;
  logic [PW-1:0]       pc;
  logic                halted;
  logic [STATUS_W-1:0] status;
  logic [PC_OUT_W-1:0] program_end;

  // Item and work registers.
  logic [OPCODE_W-1:0] op;
  logic [WORD_W-1:0]   a;
  logic [WORD_W-1:0]   rv;
  logic [WORD_W-1:0]   x;
  logic [WORD_W-1:0]   y;
  logic [WORD_W-1:0]   r;
  logic                skip;
  logic [STATUS_W-1:0] fault;

  // Divider registers.
  logic [WORD_W-1:0] dq;
  logic [WORD_W-1:0] drem;
  logic [WORD_W-1:0] dmy;
  logic [4:0]        dcnt;
  logic              dneg;

  // Effective program end, clamped to the program space.
  logic [WORD_W-1:0] end_w;
  logic [PW-1:0]     end_pc;
  assign end_w  = (WORD_W'(program_end) > WORD_W'(PROGRAM_DEPTH)) ?
                  WORD_W'(PROGRAM_DEPTH) : WORD_W'(program_end);
  assign end_pc = end_w[PW-1:0];

  // Common decodes.
  logic [AW-1:0]      top_idx;
  logic [AW-1:0]      below_idx;
  logic [AW-1:0]      push_idx;
  logic [AW-1:0]      slot_idx;
  logic               slot_ok;
  logic [PW-1:0]      jt;
  logic signed [33:0] int_n;
  logic               int_ok;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;

  assign cnt_m1    = cnt - CW'(1);
  assign cnt_m2    = cnt - CW'(2);
  assign top_idx   = cnt_m1[AW-1:0];
  assign below_idx = cnt_m2[AW-1:0];
  assign push_idx  = cnt[AW-1:0];
  assign slot_idx  = a[AW-1:0];
  assign slot_ok   = !a[WORD_W-1] && (a < WORD_W'(STACK_DEPTH));
  assign jt        = (a[WORD_W-1] || (a > WORD_W'(end_pc))) ? end_pc : a[PW-1:0];
  assign int_n     = $signed(34'(cnt)) + $signed({{2{a[WORD_W-1]}}, a});
  assign int_ok    = !int_n[33] && (int_n <= $signed(34'(STACK_DEPTH)));

  // Fault check on the item about to run.
  logic [STATUS_W-1:0] fault_now;
  always_comb begin
    fault_now = ST_RUN;
    if (pc >= end_pc) begin
      fault_now = ST_END;
    end else begin
      case (op)
        OP_NOP, OP_JMP: fault_now = ST_RUN;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQU, OP_LTH, OP_SWP:
          if (cnt < CW'(2)) fault_now = ST_RANGE;
        OP_LIT: if (cnt >= CW'(STACK_DEPTH)) fault_now = ST_RANGE;
        OP_LOD: if (cnt >= CW'(STACK_DEPTH) || !slot_ok) fault_now = ST_RANGE;
        OP_STO: if (cnt == '0 || !slot_ok) fault_now = ST_RANGE;
        OP_INT: if (!int_ok) fault_now = ST_RANGE;
        OP_JPC, OP_WRT: if (cnt == '0) fault_now = ST_RANGE;
        OP_RED: if (!slot_ok) fault_now = ST_RANGE;
        default: fault_now = ST_BADOP;
      endcase
    end
  end

  // Status to the controller.
  assign sts.early_done = halted || (fault_now != ST_RUN);
  assign sts.div_go     = (op == OP_DIV) && (y != '0);
  assign sts.div_last   = (dcnt == 5'd31);
  assign sts.out_free   = !res_valid || !res_stall;
  assign sts.swp_go     = (op == OP_SWP) && !skip && (fault == ST_RUN);

  // Stack read address.
  logic [AW-1:0] raddr;
  always_comb begin
    raddr = top_idx;
    if (cmd.chk && op == OP_LOD) raddr = slot_idx;
    else if (cmd.rd2)            raddr = below_idx;
  end

  // Divider step on the magnitudes.
  logic [WORD_W:0] d_sh;
  logic [WORD_W:0] d_trial;
  assign d_sh    = {drem, dq[WORD_W-1]};
  assign d_trial = d_sh - {1'b0, dmy};

  // Result of the two-operand operations other than divide.
  logic [WORD_W-1:0] alu;
  logic [WORD_W-1:0] x_in;
  assign x_in = rdata;
  always_comb begin
    case (op)
      OP_ADD:  alu = x_in + y;
      OP_SUB:  alu = x_in - y;
      OP_MUL:  alu = x_in * y;
      OP_EQU:  alu = (x_in == y) ? WORD_W'(1) : '0;
      OP_LTH:  alu = ($signed(x_in) < $signed(y)) ? WORD_W'(1) : '0;
      default: alu = '0;
    endcase
  end

  // Final update of the item.
  logic [WORD_W-1:0]   res;
  logic [PW-1:0]       npc;
  logic [PW-1:0]       pc_n;
  logic [CW-1:0]       cnt_n;
  logic                halt_n;
  logic [STATUS_W-1:0] stat_n;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [WORD_W-1:0]   wdata;
  logic                ov;
  logic [WORD_W-1:0]   oval;

  assign res = (op == OP_DIV) ? (dneg ? (WORD_W'(0) - dq) : dq) : r;

  always_comb begin
    npc    = pc + PW'(1);
    pc_n   = pc;
    cnt_n  = cnt;
    halt_n = halted;
    stat_n = status;
    we     = 1'b0;
    waddr  = top_idx;
    wdata  = x;
    ov     = 1'b0;
    oval   = '0;
    if (cmd.swp2) begin
      we    = 1'b1;
      waddr = below_idx;
      wdata = y;
    end else if (cmd.fin_go && !skip) begin
      if (fault != ST_RUN) begin
        halt_n = 1'b1;
        stat_n = fault;
      end else begin
        case (op)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQU, OP_LTH: begin
            we    = 1'b1;
            waddr = below_idx;
            wdata = res;
            cnt_n = cnt_m1;
          end
          OP_LIT: begin
            we    = 1'b1;
            waddr = push_idx;
            wdata = a;
            cnt_n = cnt + CW'(1);
          end
          OP_LOD: begin
            we    = 1'b1;
            waddr = push_idx;
            wdata = y;
            cnt_n = cnt + CW'(1);
          end
          OP_STO: begin
            we    = 1'b1;
            waddr = slot_idx;
            wdata = y;
            cnt_n = cnt_m1;
          end
          OP_INT: cnt_n = int_n[CW-1:0];
          OP_JMP: npc = jt;
          OP_JPC: begin
            if (y == '0) npc = jt;
            cnt_n = cnt_m1;
          end
          OP_RED: begin
            we    = 1'b1;
            waddr = slot_idx;
            wdata = rv;
          end
          OP_WRT: begin
            ov    = 1'b1;
            oval  = y;
            cnt_n = cnt_m1;
          end
          OP_SWP: begin
            we    = 1'b1;
            waddr = top_idx;
            wdata = x;
          end
          default: we = 1'b0;
        endcase
        pc_n = npc;
        if (npc >= end_pc) begin
          halt_n = 1'b1;
          stat_n = ST_END;
        end
      end
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      pc          <= '0;
      halted      <= 1'b0;
      status      <= ST_RUN;
      program_end <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) program_end <= cfg_data;
      if (cmd.fin_go) begin
        cnt    <= cnt_n;
        pc     <= pc_n;
        halted <= halt_n;
        status <= stat_n;
      end
      if (cmd.fin_go)       res_valid <= 1'b1;
      else if (!res_stall)  res_valid <= 1'b0;
    end
  end

  // Item, operand and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= in_item.opcode;
      a  <= in_item.operand;
      rv <= in_item.read_value;
    end
    if (cmd.chk) begin
      skip  <= halted;
      fault <= halted ? ST_RUN : fault_now;
    end
    if (cmd.rd2) y <= rdata;
    if (cmd.exec) begin
      x    <= rdata;
      r    <= alu;
      dq   <= rdata[WORD_W-1] ? (WORD_W'(0) - rdata) : rdata;
      dmy  <= y[WORD_W-1] ? (WORD_W'(0) - y) : y;
      drem <= '0;
      dcnt <= '0;
      dneg <= rdata[WORD_W-1] ^ y[WORD_W-1];
      if (op == OP_DIV && y == '0 && fault == ST_RUN) fault <= ST_DIV0;
    end
    if (cmd.div_step) begin
      dcnt <= dcnt + 5'd1;
      if (!d_trial[WORD_W]) begin
        drem <= d_trial[WORD_W-1:0];
        dq   <= {dq[WORD_W-2:0], 1'b1};
      end else begin
        drem <= d_sh[WORD_W-1:0];
        dq   <= {dq[WORD_W-2:0], 1'b0};
      end
    end
    if (cmd.fin_go) begin
      res_item.next_pc   <= PC_OUT_W'(WORD_W'(pc_n));
      res_item.out_valid <= ov;
      res_item.out_value <= oval;
      res_item.status    <= halt_n ? stat_n : ST_RUN;
    end
  end

endmodule

// ===== sv/stack_machine_executor.sv =====
// Stack machine executor: runs one instruction per input item.
// Input channel (in_valid/in_stall/in_item): the fetcher presents the
// instruction at the address last reported in next_pc, with the value
// for a read instruction. The block stalls the input while it works.
// Result channel (res_valid/res_stall/res_item): one result item per
// input item, carrying the next fetch address, an emitted value for a
// write instruction, and the status (nonzero once halted).
// Configuration (cfg_valid/cfg_ready/cfg_data): program_end, always
// ready; write it only while no item is in flight.
// Steps: check with the first stack read, second stack read, execute,
// then the final step that writes the stack and registers the result;
// an item that is ignored or rejected at the check step goes straight
// to the final step, and divide by a nonzero value runs the
// one-bit-per-cycle divider between execute and the final step. Swap
// adds a second write after the final step. A new item is taken only in idle.
// The result sits in an output register, so the next item is accepted
// while it waits; a stalled receiver holds the following item in its
// final step. After reset the stack is empty, the counter is zero,
// program_end is zero and no result is pending.
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                res_valid,
  input  logic                res_stall,
  output res_item_t           res_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PC_OUT_W-1:0] cfg_data
);

  smx_cmd_t cmd;
  smx_sts_t sts;
  logic     busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  // Sequencer.
  smx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (in_valid),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Stack, registers and divider.
  smx_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== sv/smx_check.sv =====
module smx_check
  import smx_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input in_item_t            in_item,
  input logic                res_valid,
  input logic                res_stall,
  input res_item_t           res_item,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [PC_OUT_W-1:0] cfg_data
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // An accepted item keeps the input stalled while it runs.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // Without an emitted value the value field is zero.
  a_quiet_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.out_valid |-> res_item.out_value == '0)
    else $error("value present without emit");

  // Status stays within its defined codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.status <= ST_RANGE)
    else $error("undefined status code");

endmodule

bind stack_machine_executor smx_check u_smx_check (.*);

// ===== tb/sv/tb.sv =====
module tb;
  import smx_pkg::*;

  localparam int DEPTH     = STACK_DEPTH_DEF;
  localparam int PROG_MAX  = PROGRAM_DEPTH_DEF;
  localparam int WDOG_MAX  = 3000;
  localparam int SETTLE    = 60;
  localparam int HOLD_LEN  = 80;

  // Copies of the machine state: 0 tracks the block, 1 tracks what has
  // been queued for the fetcher, 2 is scratch for trying a candidate.
  localparam int M_BLOCK = 0;
  localparam int M_QUEUE = 1;
  localparam int M_TRY   = 2;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic res_valid;
  logic res_stall;
  res_item_t res_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [PC_OUT_W-1:0] cfg_data;

  logic [WORD_W-1:0] stk [3][DEPTH];
  bit                written [3][DEPTH];
  int                top [3];
  int unsigned       pc [3];
  bit                hlt [3];
  logic [STATUS_W-1:0] kept [3];
  int unsigned       pend [3];

  in_item_t  fetch_q[$];
  res_item_t expected_q[$];
  int        errors;
  int        quiet_cycles;
  bit        in_fire;
  int        idle_mode;
  bit        hold_req;
  bit        hold_done;
  int        hold_left;

  stack_machine_executor DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Execute one instruction on state copy k; flags reads of unwritten slots.
  function automatic void execute(input int k, input in_item_t it,
                                  output res_item_t r, output bit bad_read);
    int unsigned lim;
    int unsigned npc;
    longint sa;
    longint nt;
    int t;
    logic [STATUS_W-1:0] err;
    bit emit;
    logic [WORD_W-1:0] val;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] res;
    lim = (pend[k] > PROG_MAX) ? PROG_MAX : pend[k];
    sa = longint'(it.operand);
    t = top[k];
    npc = pc[k] + 1;
    err = ST_RUN;
    emit = 1'b0;
    val = '0;
    res = '0;
    bad_read = 1'b0;
    if (!hlt[k] && pc[k] >= lim) begin
      hlt[k] = 1'b1;
      kept[k] = ST_END;
    end
    if (!hlt[k]) begin
      case (it.opcode)
        OP_NOP: ;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQU, OP_LTH: begin
          if (t < 1) begin
            err = ST_RANGE;
          end else begin
            x = stk[k][t-1];
            y = stk[k][t];
            bad_read = !written[k][t-1] || !written[k][t];
            case (it.opcode)
              OP_ADD: res = x + y;
              OP_SUB: res = x - y;
              OP_MUL: res = x * y;
              OP_DIV: begin
                if (y == 0) err = ST_DIV0;
                else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) res = x;
                else res = $signed(x) / $signed(y);
              end
              OP_EQU: res = (x == y) ? 32'd1 : 32'd0;
              default: res = ($signed(x) < $signed(y)) ? 32'd1 : 32'd0;
            endcase
            if (err == ST_RUN) begin
              stk[k][t-1] = res;
              written[k][t-1] = 1'b1;
              top[k] = t - 1;
            end
          end
        end
        OP_LIT: begin
          if (t >= DEPTH - 1) begin
            err = ST_RANGE;
          end else begin
            stk[k][t+1] = it.operand;
            written[k][t+1] = 1'b1;
            top[k] = t + 1;
          end
        end
        OP_LOD: begin
          if (t >= DEPTH - 1 || sa < 0 || sa >= DEPTH) begin
            err = ST_RANGE;
          end else begin
            bad_read = !written[k][sa];
            stk[k][t+1] = stk[k][sa];
            written[k][t+1] = 1'b1;
            top[k] = t + 1;
          end
        end
        OP_STO: begin
          if (t < 0 || sa < 0 || sa >= DEPTH) begin
            err = ST_RANGE;
          end else begin
            bad_read = !written[k][t];
            stk[k][sa] = stk[k][t];
            written[k][sa] = 1'b1;
            top[k] = t - 1;
          end
        end
        OP_INT: begin
          nt = longint'(t) + sa;
          if (nt < -1 || nt > DEPTH - 1) err = ST_RANGE;
          else top[k] = int'(nt);
        end
        OP_JMP: npc = (sa < 0 || sa > lim) ? lim : int'(sa);
        OP_JPC: begin
          if (t < 0) begin
            err = ST_RANGE;
          end else begin
            bad_read = !written[k][t];
            if (stk[k][t] == 0) npc = (sa < 0 || sa > lim) ? lim : int'(sa);
            top[k] = t - 1;
          end
        end
        OP_RED: begin
          if (sa < 0 || sa >= DEPTH) begin
            err = ST_RANGE;
          end else begin
            stk[k][sa] = it.read_value;
            written[k][sa] = 1'b1;
          end
        end
        OP_WRT: begin
          if (t < 0) begin
            err = ST_RANGE;
          end else begin
            bad_read = !written[k][t];
            emit = 1'b1;
            val = stk[k][t];
            top[k] = t - 1;
          end
        end
        OP_SWP: begin
          if (t < 1) begin
            err = ST_RANGE;
          end else begin
            bad_read = !written[k][t] || !written[k][t-1];
            x = stk[k][t];
            stk[k][t] = stk[k][t-1];
            stk[k][t-1] = x;
          end
        end
        default: err = ST_BADOP;
      endcase
      if (err != ST_RUN) begin
        hlt[k] = 1'b1;
        kept[k] = err;
      end else begin
        pc[k] = npc;
        if (pc[k] >= lim) begin
          hlt[k] = 1'b1;
          kept[k] = ST_END;
        end
      end
    end
    r.next_pc = pc[k][PC_OUT_W-1:0];
    r.out_valid = emit;
    r.out_value = emit ? val : '0;
    r.status = hlt[k] ? kept[k] : ST_RUN;
  endfunction

  // Queue an item for the fetcher and advance the queued-state copy.
  task automatic offer(input in_item_t it);
    res_item_t r;
    bit bad;
    execute(M_QUEUE, it, r, bad);
    fetch_q.push_back(it);
  endtask

  function automatic in_item_t make_item(input logic [OPCODE_W-1:0] op,
                                         input logic [WORD_W-1:0] a);
    in_item_t it;
    it.opcode = op;
    it.operand = a;
    it.read_value = $urandom;
    return it;
  endfunction

  // Propose a random instruction; operands favor values that keep running.
  function automatic in_item_t propose();
    in_item_t it;
    int unsigned lim;
    lim = (pend[M_QUEUE] > PROG_MAX) ? PROG_MAX : pend[M_QUEUE];
    it = make_item(OPCODE_W'($urandom_range(0, 15)), $urandom);
    case (it.opcode)
      OP_LIT: if ($urandom_range(0, 1) == 0) it.operand = $urandom_range(0, 20) - 10;
      OP_LOD, OP_STO, OP_RED:
        it.operand = ($urandom_range(0, 9) == 0) ? $urandom_range(0, DEPTH - 1)
                                                 : $urandom_range(0, 15);
      OP_INT: it.operand = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) - 20
                                                        : $urandom_range(0, 4) - 2;
      OP_JMP, OP_JPC: it.operand = $urandom_range(0, (lim > 60 ? 60 : lim) - 1);
      default: ;
    endcase
    return it;
  endfunction

  // Random instructions that neither halt nor read unwritten slots.
  task automatic random_program(input int count);
    in_item_t it;
    res_item_t r;
    bit bad;
    bit found;
    for (int n = 0; n < count; n++) begin
      found = 1'b0;
      for (int tries = 0; tries < 30 && !found; tries++) begin
        it = propose();
        stk[M_TRY] = stk[M_QUEUE];
        written[M_TRY] = written[M_QUEUE];
        top[M_TRY] = top[M_QUEUE];
        pc[M_TRY] = pc[M_QUEUE];
        hlt[M_TRY] = hlt[M_QUEUE];
        kept[M_TRY] = kept[M_QUEUE];
        pend[M_TRY] = pend[M_QUEUE];
        execute(M_TRY, it, r, bad);
        found = !bad && !hlt[M_TRY];
      end
      if (!found) it = make_item(OP_JMP, 0);
      offer(it);
    end
  endtask

  // Wait until the block has drained, then let it settle.
  task automatic drain();
    while (fetch_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_end(input logic [PC_OUT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    pend[M_BLOCK] = value;
    pend[M_QUEUE] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: presents queued items, idling at random per the current mode.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (fetch_q.size() != 0 && !(idle_mode == 1 && $urandom_range(0, 99) < 23)
          && !(idle_mode == 2 && $urandom_range(0, 99) < 70)) begin
        in_valid <= 1'b1;
        in_item <= fetch_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per mode, plus one long hold-off when asked.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      res_stall <= 1'b1;
    end else begin
      res_stall <= (idle_mode == 1 && $urandom_range(0, 99) < 70) ||
                   (idle_mode == 2 && $urandom_range(0, 99) < 23);
    end
  end

  // Check results against the oldest expectation, then predict new items.
  always @(posedge clk) begin
    res_item_t want;
    bit bad;
    in_fire <= in_valid && !in_stall && !rst;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", res_item);
      end else begin
        want = expected_q.pop_front();
        if (res_item.next_pc !== want.next_pc || res_item.out_valid !== want.out_valid ||
            res_item.out_value !== want.out_value || res_item.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected pc=%0d v=%0b val=%h st=%0d, got pc=%0d v=%0b val=%h st=%0d",
                     want.next_pc, want.out_valid, want.out_value, want.status,
                     res_item.next_pc, res_item.out_valid, res_item.out_value,
                     res_item.status);
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      execute(M_BLOCK, in_item, want, bad);
      expected_q.push_back(want);
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("FAIL stack_machine_executor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    quiet_cycles = 0;
    idle_mode = 1;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < DEPTH; s++) begin
        stk[k][s] = '0;
        written[k][s] = 1'b0;
      end
      top[k] = -1;
      pc[k] = 0;
      hlt[k] = 1'b0;
      kept[k] = ST_RUN;
      pend[k] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part with the counter limit above the program space.
    write_end(11'h7FF);
    offer(make_item(OP_LIT, 32'h7FFF_FFFF));
    offer(make_item(OP_LIT, 32'd1));
    offer(make_item(OP_ADD, $urandom));
    offer(make_item(OP_WRT, $urandom));
    offer(make_item(OP_LIT, 32'h8000_0000));
    offer(make_item(OP_LIT, 32'hFFFF_FFFF));
    offer(make_item(OP_DIV, $urandom));
    offer(make_item(OP_WRT, $urandom));
    offer(make_item(OP_LIT, -32'sd7));
    offer(make_item(OP_LIT, 32'd2));
    offer(make_item(OP_DIV, $urandom));
    offer(make_item(OP_LIT, 32'd3));
    offer(make_item(OP_LTH, $urandom));
    offer(make_item(OP_LIT, 32'd1));
    offer(make_item(OP_EQU, $urandom));
    offer(make_item(OP_LIT, -32'sd5));
    offer(make_item(OP_SWP, $urandom));
    offer(make_item(OP_MUL, $urandom));
    offer(make_item(OP_RED, DEPTH - 1));
    offer(make_item(OP_LOD, DEPTH - 1));
    offer(make_item(OP_STO, 32'd0));
    offer(make_item(OP_JPC, 32'd0));
    offer(make_item(OP_LIT, 32'd0));
    offer(make_item(OP_JPC, 32'd0));
    // Fill the stack to its last slot and then empty it again.
    offer(make_item(OP_INT, DEPTH - 1));
    offer(make_item(OP_LIT, $urandom));
    offer(make_item(OP_WRT, $urandom));
    offer(make_item(OP_INT, -(DEPTH - 1)));
    offer(make_item(OP_NOP, $urandom));
    random_program(150);
    offer(make_item(OP_JMP, 32'd0));
    drain();

    // Full program space, receiver idles less, one long hold-off.
    write_end(PROG_MAX);
    idle_mode = 2;
    hold_req = 1'b1;
    random_program(200);
    offer(make_item(OP_JMP, 32'd0));
    drain();

    // Short program, no idling.
    write_end(11'd40);
    idle_mode = 3;
    random_program(200);
    offer(make_item(OP_JMP, 32'd0));
    drain();

    // One terminal event, then items the halted block ignores.
    idle_mode = 1;
    pick = $urandom_range(0, 5);
    case (pick)
      0: begin
        write_end(11'd0);
        offer(make_item(OP_NOP, $urandom));
      end
      1: begin
        offer(make_item(OP_LIT, $urandom));
        offer(make_item(OP_LIT, 32'd0));
        offer(make_item(OP_DIV, $urandom));
      end
      2: offer(make_item(OPCODE_W'($urandom_range(16, 31)), $urandom));
      3: offer(make_item(OP_LOD, ($urandom_range(0, 1) == 0) ? -32'sd1 : DEPTH));
      4: offer(make_item(OP_JMP, -32'sd5));
      default: begin
        write_end(11'd2);
        offer(make_item(OP_LIT, $urandom));
        offer(make_item(OP_WRT, $urandom));
      end
    endcase
    for (int n = 0; n < 6; n++) begin
      offer(make_item(OPCODE_W'($urandom_range(0, 31)), $urandom));
    end
    drain();

    if (errors == 0) begin
      $display("PASS stack_machine_executor");
    end else begin
      $display("FAIL stack_machine_executor");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/smx_pkg.sv
sv/smx_ctrl.sv
sv/smx_dp.sv
sv/stack_machine_executor.sv
sv/smx_check.sv
tb/sv/tb.sv
